FILE: rtl/pdoib_pkg.sv
// Shared types, codes and the threshold function for the PWM duty arbiter.
package pdoib_pkg;

  localparam int unsigned CHANNEL_W = 3;
  localparam int unsigned DUTY_W    = 16;
  localparam int unsigned DELAY_W   = 8;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned THR_W     = 9;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned ACT_W     = 2;

  localparam int unsigned CHANNELS_DEFAULT = 8;

  localparam logic [CMD_W-1:0] CMD_SET_DUTY = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_OVR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLR_OVR  = 2'd2;

  localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DISABLE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ENABLE  = 2'd2;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  // floor(x/25) == (x*5243)>>17 for every x below 43690
  localparam logic [12:0] RECIP_25 = 13'd5243;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [CHANNEL_W-1:0] channel;
    logic [DUTY_W-1:0]    duty;
    logic                 fault_override_en;
    logic [DUTY_W-1:0]    fault_override_duty;
    logic                 voltage_override_en;
    logic [DUTY_W-1:0]    voltage_override_duty;
    logic [DELAY_W-1:0]   inrush_delay;
    logic [PCT_W-1:0]     threshold_pct;
  } item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  last_duty;
    logic [DELAY_W-1:0] inrush_count;
    logic               ovr_on;
    logic [DUTY_W-1:0]  ovr_value;
  } chan_state_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_out;
    logic [ACT_W-1:0]  diag_action;
  } result_t;

  // min(pct,100)*256/100, as pct*64/25 via reciprocal multiply
  function automatic logic [THR_W-1:0] threshold_of(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0] p;
    logic [12:0]      x;
    logic [25:0]      prod;
    p    = (pct > PCT_MAX) ? PCT_MAX : pct;
    x    = {p, 6'b0};
    prod = 26'(x) * 26'(RECIP_25);
    return prod[25:17];
  endfunction

endpackage

FILE: rtl/pdoib_decide.sv
// Duty arbitration and inrush blanking decision for one word.
module pdoib_decide import pdoib_pkg::*; #(
  parameter int unsigned DEPTH = CHANNELS_DEFAULT
) (
  input  item_t       item_i,
  input  chan_state_t cur_i,
  output result_t     res_o,
  output logic        wr_en_o,
  output chan_state_t nxt_o
);

  logic              in_range;
  logic [THR_W-1:0]  thr;
  logic [DUTY_W-1:0] thr_ext;
  logic [DUTY_W-1:0] sel;

  assign in_range = {1'b0, item_i.channel} < (CHANNEL_W+1)'(DEPTH);
  assign thr      = threshold_of(item_i.threshold_pct);
  assign thr_ext  = DUTY_W'(thr);

  always_comb begin
    if (item_i.fault_override_en) begin
      sel = item_i.fault_override_duty;
    end else if (item_i.voltage_override_en) begin
      sel = item_i.voltage_override_duty;
    end else if (cur_i.ovr_on) begin
      sel = cur_i.ovr_value;
    end else begin
      sel = item_i.duty;
    end
  end

  always_comb begin
    res_o   = '0;
    wr_en_o = 1'b0;
    nxt_o   = cur_i;
    if (in_range) begin
      case (item_i.command)
        CMD_SET_OVR: begin
          wr_en_o         = 1'b1;
          nxt_o.ovr_on    = 1'b1;
          nxt_o.ovr_value = item_i.duty;
        end
        CMD_CLR_OVR: begin
          wr_en_o      = 1'b1;
          nxt_o.ovr_on = 1'b0;
        end
        CMD_SET_DUTY: begin
          wr_en_o         = 1'b1;
          nxt_o.last_duty = sel;
          res_o.duty_out  = sel;
          if (sel == '0) begin
            nxt_o.inrush_count = '0;
          end else if (item_i.inrush_delay == '0) begin
            res_o.diag_action  = ACT_ENABLE;
            nxt_o.inrush_count = '0;
          end else if (sel >= thr_ext) begin
            if (cur_i.last_duty < thr_ext) begin
              // just crossed the threshold: restart blanking
              res_o.diag_action  = ACT_DISABLE;
              nxt_o.inrush_count = '0;
            end else if (cur_i.inrush_count < item_i.inrush_delay) begin
              nxt_o.inrush_count = cur_i.inrush_count + 1'b1;
            end else begin
              res_o.diag_action = ACT_ENABLE;
            end
          end else begin
            res_o.diag_action  = ACT_DISABLE;
            nxt_o.inrush_count = '0;
          end
        end
        default: begin
          wr_en_o = 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/pdoib_chan_state.sv
// Per-channel state registers: last duty, inrush count, stored override.
module pdoib_chan_state import pdoib_pkg::*; #(
  parameter int unsigned DEPTH = CHANNELS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CHANNEL_W-1:0] channel_i,
  output chan_state_t          rd_state_o,
  input  logic                 wr_en_i,
  input  chan_state_t          wr_state_i
);

  chan_state_t st_q [DEPTH];

  always_comb begin
    rd_state_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (channel_i == CHANNEL_W'(i)) begin
        rd_state_o = st_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        st_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (wr_en_i && channel_i == CHANNEL_W'(i)) begin
          st_q[i] <= wr_state_i;
        end
      end
    end
  end

endmodule

FILE: rtl/pwm_duty_override_inrush_blanking.sv
// PWM duty arbiter with inrush diagnostic blanking: top level.
//
// Input channel: one word per command (set duty, set or clear the stored
// diagnostic override of a channel), with the intercept enables and duties
// and the channel's blanking delay and threshold percentage. Output channel:
// one word per input word, the selected duty and the diagnostic action.
// Both channels move a word on a clock edge with valid high and stall low.
//
// The path is an input register, then the arbitration and blanking logic, then
// the result register, which holds the result word for the receiver. One word
// is taken every cycle while the receiver does not stall the result register;
// the per-channel state is read and written in the same cycle so back-to-back
// words to one channel see each other's updates.
//
// Reset clears all per-channel state (last duty, inrush count, override) and
// both valid flags. When the receiver stalls, the result register holds; the
// input register still loads while it is empty or while the result register
// can take its word, and otherwise in_stall_o rises in the same cycle.
module pwm_duty_override_inrush_blanking import pdoib_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [CHANNEL_W-1:0] channel_i,
  input  logic [DUTY_W-1:0]    duty_i,
  input  logic                 fault_override_en_i,
  input  logic [DUTY_W-1:0]    fault_override_duty_i,
  input  logic                 voltage_override_en_i,
  input  logic [DUTY_W-1:0]    voltage_override_duty_i,
  input  logic [DELAY_W-1:0]   inrush_delay_i,
  input  logic [PCT_W-1:0]     threshold_pct_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DUTY_W-1:0]    duty_out_o,
  output logic [ACT_W-1:0]     diag_action_o
);

  // only channel codes below both CHANNELS and the field range can be hit
  localparam int unsigned DEPTH =
    (CHANNELS < (1 << CHANNEL_W)) ? CHANNELS : (1 << CHANNEL_W);

  logic        s1_valid_q, s1_valid_d;
  item_t       s1_item_q;
  logic        res_valid_q, res_valid_d;
  result_t     res_q;
  logic        res_ready;
  logic        adv;
  logic        in_acc;
  chan_state_t cur_state;
  chan_state_t nxt_state;
  logic        wr_en;
  result_t     res_d;

  assign res_ready  = !res_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && res_ready;
  assign in_stall_o = s1_valid_q && !res_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_acc || (s1_valid_q && !res_ready);
  assign res_valid_d = adv || (res_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q.command               <= command_i;
      s1_item_q.channel               <= channel_i;
      s1_item_q.duty                  <= duty_i;
      s1_item_q.fault_override_en     <= fault_override_en_i;
      s1_item_q.fault_override_duty   <= fault_override_duty_i;
      s1_item_q.voltage_override_en   <= voltage_override_en_i;
      s1_item_q.voltage_override_duty <= voltage_override_duty_i;
      s1_item_q.inrush_delay          <= inrush_delay_i;
      s1_item_q.threshold_pct         <= threshold_pct_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  pdoib_chan_state #(
    .DEPTH (DEPTH)
  ) u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .channel_i  (s1_item_q.channel),
    .rd_state_o (cur_state),
    .wr_en_i    (wr_en && adv),
    .wr_state_i (nxt_state)
  );

  pdoib_decide #(
    .DEPTH (DEPTH)
  ) u_decide (
    .item_i  (s1_item_q),
    .cur_i   (cur_state),
    .res_o   (res_d),
    .wr_en_o (wr_en),
    .nxt_o   (nxt_state)
  );

  assign out_valid_o   = res_valid_q;
  assign duty_out_o    = res_q.duty_out;
  assign diag_action_o = res_q.diag_action;

  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_ovr_cmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_item_q.command != CMD_SET_DUTY) |=>
      (out_valid_o && duty_out_o == '0 && diag_action_o == ACT_NONE))
    else $error("non set-duty word gave a nonzero result");

  a_zero_duty_no_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && duty_out_o == '0) |-> (diag_action_o == ACT_NONE))
    else $error("zero duty with a diagnostic action");

  a_action_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (diag_action_o == ACT_NONE || diag_action_o == ACT_DISABLE ||
                     diag_action_o == ACT_ENABLE))
    else $error("bad diagnostic action code");

endmodule

FILE: verif/pdoib_checker.sv
// Scoreboard for the PWM duty arbiter: predicts each result word and compares it.
module pdoib_checker import pdoib_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [CHANNEL_W-1:0] channel_i,
  input  logic [DUTY_W-1:0]    duty_i,
  input  logic                 fault_override_en_i,
  input  logic [DUTY_W-1:0]    fault_override_duty_i,
  input  logic                 voltage_override_en_i,
  input  logic [DUTY_W-1:0]    voltage_override_duty_i,
  input  logic [DELAY_W-1:0]   inrush_delay_i,
  input  logic [PCT_W-1:0]     threshold_pct_i,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  logic [DUTY_W-1:0]    duty_out_o,
  input  logic [ACT_W-1:0]     diag_action_o,
  output int                   err_count_o,
  output int                   pending_o
);

  logic [DUTY_W-1:0]  last_duty_q  [CHANNELS];
  logic [DELAY_W-1:0] inrush_cnt_q [CHANNELS];
  logic               ovr_on_q     [CHANNELS];
  logic [DUTY_W-1:0]  ovr_value_q  [CHANNELS];

  result_t duty_action_q [$];
  int      errs = 0;

  // Stores or clears the channel's override, or selects the duty by priority and updates the channel's blanking state.
  function automatic result_t arbitrate(input item_t w);
    result_t           r;
    int unsigned       ch;
    int unsigned       pct_sat;
    int unsigned       thr;
    logic [DUTY_W-1:0] sel;
    r  = '0;
    ch = w.channel;
    if (ch >= CHANNELS) return r;
    if (w.command == CMD_SET_OVR) begin
      ovr_on_q[ch]    = 1'b1;
      ovr_value_q[ch] = w.duty;
      return r;
    end
    if (w.command == CMD_CLR_OVR) begin
      ovr_on_q[ch] = 1'b0;
      return r;
    end
    if (w.command != CMD_SET_DUTY) return r;

    if (w.fault_override_en) sel = w.fault_override_duty;
    else if (w.voltage_override_en) sel = w.voltage_override_duty;
    else if (ovr_on_q[ch]) sel = ovr_value_q[ch];
    else sel = w.duty;

    pct_sat = (w.threshold_pct > 7'd100) ? 100 : w.threshold_pct;
    thr     = (pct_sat * 256) / 100;

    r.diag_action = ACT_NONE;
    if (sel == '0) begin
      inrush_cnt_q[ch] = '0;
    end else if (w.inrush_delay == '0) begin
      r.diag_action    = ACT_ENABLE;
      inrush_cnt_q[ch] = '0;
    end else if (int'(sel) >= thr) begin
      // rising through the threshold restarts blanking
      if (int'(last_duty_q[ch]) < thr) begin
        r.diag_action    = ACT_DISABLE;
        inrush_cnt_q[ch] = '0;
      end else if (inrush_cnt_q[ch] < w.inrush_delay) begin
        inrush_cnt_q[ch] = inrush_cnt_q[ch] + 1'b1;
      end else begin
        r.diag_action = ACT_ENABLE;
      end
    end else begin
      r.diag_action    = ACT_DISABLE;
      inrush_cnt_q[ch] = '0;
    end
    last_duty_q[ch] = sel;
    r.duty_out      = sel;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   w;
    result_t want;
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        last_duty_q[c]  = '0;
        inrush_cnt_q[c] = '0;
        ovr_on_q[c]     = 1'b0;
        ovr_value_q[c]  = '0;
      end
      duty_action_q.delete();
      pending_o   <= 0;
      err_count_o <= errs;
    end else begin
      // check the outgoing word before queuing the incoming one
      if (out_valid_o && !out_stall_i) begin
        if (duty_action_q.size() == 0) begin
          $error("result word with none expected: duty_out %0d diag_action %0d",
                 duty_out_o, diag_action_o);
          errs++;
        end else begin
          want = duty_action_q.pop_front();
          if (duty_out_o !== want.duty_out) begin
            $error("duty_out: expected %0d, got %0d", want.duty_out, duty_out_o);
            errs++;
          end
          if (diag_action_o !== want.diag_action) begin
            $error("diag_action: expected %0d, got %0d", want.diag_action, diag_action_o);
            errs++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        w = '{command_i, channel_i, duty_i, fault_override_en_i, fault_override_duty_i,
              voltage_override_en_i, voltage_override_duty_i, inrush_delay_i,
              threshold_pct_i};
        duty_action_q.push_back(arbitrate(w));
      end
      pending_o   <= duty_action_q.size();
      err_count_o <= errs;
    end
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the PWM duty arbiter: clock, reset, stimulus and verdict.
module tb_top;
  import pdoib_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
  localparam int               RANDOM_WORDS = 930;
  localparam int               CALM_WORDS   = 100;

  logic                 clk_i                   = 1'b0;
  logic                 rst_ni                  = 1'b0;
  logic                 in_valid_i              = 1'b0;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     command_i               = '0;
  logic [CHANNEL_W-1:0] channel_i               = '0;
  logic [DUTY_W-1:0]    duty_i                  = '0;
  logic                 fault_override_en_i     = 1'b0;
  logic [DUTY_W-1:0]    fault_override_duty_i   = '0;
  logic                 voltage_override_en_i   = 1'b0;
  logic [DUTY_W-1:0]    voltage_override_duty_i = '0;
  logic [DELAY_W-1:0]   inrush_delay_i          = '0;
  logic [PCT_W-1:0]     threshold_pct_i         = '0;
  logic                 out_valid_o;
  logic                 out_stall_i             = 1'b0;
  logic [DUTY_W-1:0]    duty_out_o;
  logic [ACT_W-1:0]     diag_action_o;

  int err_count;
  int pending;

  bit calm     = 1'b0;
  bit idle_on  = 1'b1;
  bit stall_on = 1'b1;

  logic [DELAY_W-1:0] delay_prof [8];
  logic [PCT_W-1:0]   pct_prof   [8];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  pwm_duty_override_inrush_blanking uut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .command_i              (command_i),
    .channel_i              (channel_i),
    .duty_i                 (duty_i),
    .fault_override_en_i    (fault_override_en_i),
    .fault_override_duty_i  (fault_override_duty_i),
    .voltage_override_en_i  (voltage_override_en_i),
    .voltage_override_duty_i(voltage_override_duty_i),
    .inrush_delay_i         (inrush_delay_i),
    .threshold_pct_i        (threshold_pct_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .duty_out_o             (duty_out_o),
    .diag_action_o          (diag_action_o)
  );

  pdoib_checker checker_i (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .command_i              (command_i),
    .channel_i              (channel_i),
    .duty_i                 (duty_i),
    .fault_override_en_i    (fault_override_en_i),
    .fault_override_duty_i  (fault_override_duty_i),
    .voltage_override_en_i  (voltage_override_en_i),
    .voltage_override_duty_i(voltage_override_duty_i),
    .inrush_delay_i         (inrush_delay_i),
    .threshold_pct_i        (threshold_pct_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .duty_out_o             (duty_out_o),
    .diag_action_o          (diag_action_o),
    .err_count_o            (err_count),
    .pending_o              (pending)
  );

  function automatic item_t mk(input logic [CMD_W-1:0] cmd, input int ch, input int duty,
                               input bit fen, input int fduty, input bit ven,
                               input int vduty, input int delay, input int pct);
    item_t w;
    w.command               = cmd;
    w.channel               = CHANNEL_W'(ch);
    w.duty                  = DUTY_W'(duty);
    w.fault_override_en     = fen;
    w.fault_override_duty   = DUTY_W'(fduty);
    w.voltage_override_en   = ven;
    w.voltage_override_duty = DUTY_W'(vduty);
    w.inrush_delay          = DELAY_W'(delay);
    w.threshold_pct         = PCT_W'(pct);
    return w;
  endfunction

  // Mostly large duties, with zero and values around the threshold range mixed in.
  function automatic logic [DUTY_W-1:0] rand_duty();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel <= 3) return DUTY_W'($urandom_range(0, 300));
    return DUTY_W'($urandom_range(0, 65535));
  endfunction

  function automatic void reroll_profile(input int ch);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) delay_prof[ch] = DELAY_W'($urandom_range(0, 6));
    else if (sel < 9) delay_prof[ch] = DELAY_W'($urandom_range(1, 20));
    else delay_prof[ch] = DELAY_W'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) pct_prof[ch] = PCT_W'($urandom_range(0, 127));
    else pct_prof[ch] = PCT_W'($urandom_range(0, 100));
  endfunction

  function automatic item_t rand_word(input int ch);
    item_t w;
    int    sel;
    if ($urandom_range(0, 19) == 0) reroll_profile(ch);
    sel = $urandom_range(0, 99);
    if (sel < 85) w.command = CMD_SET_DUTY;
    else if (sel < 91) w.command = CMD_SET_OVR;
    else if (sel < 97) w.command = CMD_CLR_OVR;
    else w.command = CMD_UNUSED;
    w.channel               = CHANNEL_W'(ch);
    w.duty                  = rand_duty();
    w.fault_override_en     = ($urandom_range(0, 9) == 0);
    w.fault_override_duty   = rand_duty();
    w.voltage_override_en   = ($urandom_range(0, 9) == 0);
    w.voltage_override_duty = rand_duty();
    w.inrush_delay          = delay_prof[ch];
    w.threshold_pct         = pct_prof[ch];
    return w;
  endfunction

  function automatic int pick_gap();
    if (calm || !idle_on) return 0;
    if ($urandom_range(0, 5) == 0) return $urandom_range(1, 16);
    return 0;
  endfunction

  task automatic send_word(input item_t w, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    command_i               <= w.command;
    channel_i               <= w.channel;
    duty_i                  <= w.duty;
    fault_override_en_i     <= w.fault_override_en;
    fault_override_duty_i   <= w.fault_override_duty;
    voltage_override_en_i   <= w.voltage_override_en;
    voltage_override_duty_i <= w.voltage_override_duty;
    inrush_delay_i          <= w.inrush_delay;
    threshold_pct_i         <= w.threshold_pct;
    in_valid_i              <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // receiver stalls in bursts
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 199) == 0) stall_on = !stall_on;
      if (!calm && stall_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
    end
  end

  initial begin
    item_t plan [$];
    int    ch;
    int    spins;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    for (int c = 0; c < 8; c++) reroll_profile(c);

    plan.push_back(mk(CMD_SET_DUTY, 0, 0, 0, 0, 0, 0, 4, 50));
    plan.push_back(mk(CMD_SET_DUTY, 0, 16'hFFFF, 0, 0, 0, 0, 0, 50));
    // blanking ramp: disable on the rising step, two counts, then enable
    repeat (4) plan.push_back(mk(CMD_SET_DUTY, 1, 16'hFFFF, 0, 0, 0, 0, 2, 100));
    plan.push_back(mk(CMD_SET_DUTY, 1, 255, 0, 0, 0, 0, 2, 100));
    // percentage above hundred saturates, threshold 256
    repeat (3) plan.push_back(mk(CMD_SET_DUTY, 2, 256, 0, 0, 0, 0, 1, 127));
    plan.push_back(mk(CMD_SET_DUTY, 2, 255, 0, 0, 0, 0, 1, 127));
    plan.push_back(mk(CMD_SET_DUTY, 4, 1, 0, 0, 0, 0, 1, 0));
    // override priority chain
    plan.push_back(mk(CMD_SET_OVR, 3, 16'h1234, 0, 0, 0, 0, 1, 10));
    plan.push_back(mk(CMD_SET_DUTY, 3, 16'h0010, 0, 0, 0, 0, 1, 10));
    plan.push_back(mk(CMD_SET_DUTY, 3, 16'h0010, 0, 0, 1, 16'hABCD, 1, 10));
    plan.push_back(mk(CMD_SET_DUTY, 3, 16'h0010, 1, 16'hFFFF, 1, 16'hABCD, 1, 10));
    plan.push_back(mk(CMD_SET_DUTY, 3, 16'h0010, 1, 0, 1, 16'hABCD, 1, 10));
    plan.push_back(mk(CMD_CLR_OVR, 3, 16'hFFFF, 1, 16'hFFFF, 1, 16'hFFFF, 255, 127));
    plan.push_back(mk(CMD_SET_DUTY, 3, 16'h8000, 0, 0, 0, 0, 1, 10));
    plan.push_back(mk(CMD_UNUSED, 7, 16'hFFFF, 1, 16'hFFFF, 1, 16'hFFFF, 255, 127));
    plan.push_back(mk(CMD_SET_DUTY, 7, 16'hFFFF, 0, 0, 0, 0, 255, 127));
    plan.push_back(mk(CMD_SET_DUTY, 7, 16'hFFFF, 0, 0, 0, 0, 255, 127));
    plan.push_back(mk(CMD_SET_OVR, 7, 0, 0, 0, 0, 0, 255, 127));
    plan.push_back(mk(CMD_SET_DUTY, 7, 16'hFFFF, 0, 0, 0, 0, 255, 127));
    plan.push_back(mk(CMD_CLR_OVR, 7, 0, 0, 0, 0, 0, 0, 0));
    foreach (plan[i]) send_word(plan[i], pick_gap());

    ch = $urandom_range(0, 7);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (n == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      // stay on one channel for a while so its inrush counter can ramp
      if ($urandom_range(0, 3) == 0) ch = $urandom_range(0, 7);
      send_word(rand_word(ch), pick_gap());
    end
    in_valid_i <= 1'b0;

    spins = 0;
    while (pending != 0 && spins < 2000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (8) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/pdoib_pkg.sv
rtl/pdoib_decide.sv
rtl/pdoib_chan_state.sv
rtl/pwm_duty_override_inrush_blanking.sv
verif/pdoib_checker.sv
verif/tb_top.sv
